/* hdl/smf_pkg.sv */
// Shared constants for the sliding median filter.
`default_nettype none

package smf_pkg;

    // Default half width of the median window
    localparam int SMF_HALF_WINDOW = 5;

    // Sample width
    localparam int SMF_DATA_W = 32;

endpackage

`default_nettype wire

/* hdl/sliding_median_filter_unit.sv */
// Sliding median filter: top level with window RAM, sequencer and output register.
//
// Each input beat is one sample; s_tlast marks the last sample of a sequence. Output i is
// the median (upper middle for even counts) of samples i-HALF_WINDOW .. i+HALF_WINDOW,
// truncated at both ends, and lags the input by HALF_WINDOW beats. The last input beat
// flushes every pending output, the final one flagged by m_tlast, and the filter then
// starts a fresh sequence. The window sits in a 2*HALF_WINDOW+1 entry RAM used as a ring;
// a median reads its c samples one per cycle through the single RAM read port into rank
// lanes. An input beat that yields a median makes one such pass (c = window size, at most
// 2*HALF_WINDOW+1); a beat before the window holds HALF_WINDOW+1 samples makes none; the
// last beat makes one pass per flushed output. A finished median waits in the output
// register while the next input beat is taken.
`default_nettype none

module sliding_median_filter_unit import smf_pkg::*; #(
    parameter int HALF_WINDOW = SMF_HALF_WINDOW
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SMF_DATA_W-1:0] s_tdata,   // [31:0] sample_value
    input  wire logic                  s_tlast,   // sample_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [SMF_DATA_W-1:0] m_tdata,   // [31:0] median_value
    output logic                       m_tlast    // median_last
);

    localparam int WIN_DEPTH = 2 * HALF_WINDOW + 1;
    localparam int PTR_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int LEAD_W    = $clog2(HALF_WINDOW + 1);

    localparam logic [PTR_W-1:0]  LAST_IDX  = PTR_W'(WIN_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WIN_DEPTH);
    localparam logic [CNT_W-1:0]  FILL_CNT  = CNT_W'(HALF_WINDOW + 1);
    localparam logic [LEAD_W-1:0] LEAD_MAX  = LEAD_W'(HALF_WINDOW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_PICK
    } state_t;

    state_t                state_reg,   state_next;
    logic [PTR_W-1:0]      top_reg,     top_next;
    logic [CNT_W-1:0]      held_reg,    held_next;
    logic [LEAD_W-1:0]     lead_reg,    lead_next;
    logic                  flush_reg,   flush_next;
    logic [LEAD_W-1:0]     k_reg,       k_next;
    logic [CNT_W-1:0]      job_cnt_reg, job_cnt_next;
    logic [PTR_W-1:0]      rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]      iss_reg,     iss_next;
    logic [CNT_W-1:0]      rcv_reg,     rcv_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SMF_DATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                  m_tlast_reg,  m_tlast_next;

    logic                  s_accept;
    logic [PTR_W-1:0]      wr_addr;
    logic [CNT_W-1:0]      held_inc;
    logic [CNT_W-1:0]      flush_span;
    logic [CNT_W-1:0]      first_cnt;
    logic [LEAD_W-1:0]     k_dec;
    logic [CNT_W-1:0]      next_span;
    logic [CNT_W-1:0]      next_cnt;
    logic [PTR_W-1:0]      rd_wrap;
    logic                  issue;
    logic                  out_free;
    logic [SMF_DATA_W-1:0] ram_rdata;
    logic [SMF_DATA_W-1:0] median;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Ring pointer and window size arithmetic
    assign wr_addr    = (top_reg == LAST_IDX) ? '0 : top_reg + PTR_W'(1);
    assign held_inc   = (held_reg == DEPTH_CNT) ? held_reg : held_reg + CNT_W'(1);
    assign flush_span = CNT_W'(lead_reg) + FILL_CNT;
    assign first_cnt  = (flush_span < held_inc) ? flush_span : held_inc;
    assign k_dec      = k_reg - LEAD_W'(1);
    assign next_span  = CNT_W'(k_dec) + FILL_CNT;
    assign next_cnt   = (next_span < held_reg) ? next_span : held_reg;
    assign rd_wrap    = (rd_ptr_reg == '0) ? LAST_IDX : rd_ptr_reg - PTR_W'(1);
    assign issue      = (state_reg == S_LOAD) && (iss_reg != job_cnt_reg);

    smf_ram #(
        .WIDTH (SMF_DATA_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk     (aclk),
        .wr_en   (s_accept),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    smf_rank #(
        .DEPTH (WIN_DEPTH)
    ) u_rank (
        .clk        (aclk),
        .load_valid (rd_pend_reg),
        .load_lane  (rcv_reg[PTR_W-1:0]),
        .load_data  (ram_rdata),
        .used_count (job_cnt_reg),
        .median     (median)
    );

    // Sequencer next-state logic
    always_comb begin
        state_next    = state_reg;
        top_next      = top_reg;
        held_next     = held_reg;
        lead_next     = lead_reg;
        flush_next    = flush_reg;
        k_next        = k_reg;
        job_cnt_next  = job_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        iss_next      = iss_reg;
        rcv_next      = rcv_reg;
        rd_pend_next  = issue;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    top_next    = wr_addr;
                    held_next   = held_inc;
                    rd_ptr_next = wr_addr;
                    iss_next    = '0;
                    rcv_next    = '0;
                    if (s_tlast) begin
                        flush_next   = 1'b1;
                        k_next       = lead_reg;
                        job_cnt_next = first_cnt;
                        state_next   = S_LOAD;
                    end else begin
                        lead_next = (lead_reg == LEAD_MAX) ? lead_reg : lead_reg + LEAD_W'(1);
                        if (held_inc >= FILL_CNT) begin
                            flush_next   = 1'b0;
                            job_cnt_next = held_inc;
                            state_next   = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                // One RAM read issued and one sample received per cycle
                if (issue) begin
                    rd_ptr_next = rd_wrap;
                    iss_next    = iss_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    rcv_next = rcv_reg + CNT_W'(1);
                    if (rcv_reg + CNT_W'(1) == job_cnt_reg) begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = median;
                    m_tlast_next  = flush_reg && (k_reg == '0);
                    if (flush_reg && (k_reg != '0)) begin
                        k_next       = k_dec;
                        job_cnt_next = next_cnt;
                        rd_ptr_next  = top_reg;
                        iss_next     = '0;
                        rcv_next     = '0;
                        state_next   = S_LOAD;
                    end else begin
                        if (flush_reg) begin
                            held_next  = '0;
                            lead_next  = '0;
                            flush_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            top_reg      <= '0;
            held_reg     <= '0;
            lead_reg     <= '0;
            flush_reg    <= 1'b0;
            k_reg        <= '0;
            job_cnt_reg  <= '0;
            rd_ptr_reg   <= '0;
            iss_reg      <= '0;
            rcv_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            held_reg     <= held_next;
            lead_reg     <= lead_next;
            flush_reg    <= flush_next;
            k_reg        <= k_next;
            job_cnt_reg  <= job_cnt_next;
            rd_ptr_reg   <= rd_ptr_next;
            iss_reg      <= iss_next;
            rcv_reg      <= rcv_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

/* hdl/smf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module smf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/smf_rank.sv */
// Rank lanes: loads window samples one per cycle and picks the median by rank count.
`default_nettype none

module smf_rank import smf_pkg::*; #(
    parameter int DEPTH = 2 * SMF_HALF_WINDOW + 1
) (
    input  wire logic                       clk,
    input  wire logic                       load_valid,
    input  wire logic [$clog2(DEPTH)-1:0]   load_lane,
    input  wire logic [SMF_DATA_W-1:0]      load_data,
    input  wire logic [$clog2(DEPTH+1)-1:0] used_count,
    output logic      [SMF_DATA_W-1:0]      median
);

    localparam int LANE_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [SMF_DATA_W-1:0] vals_reg  [DEPTH];
    logic [CNT_W-1:0]      below_reg [DEPTH];
    logic [CNT_W-1:0]      upto_reg  [DEPTH];

    logic [DEPTH-1:0] lt_vec;
    logic [DEPTH-1:0] le_vec;
    logic [CNT_W-1:0] new_below;
    logic [CNT_W-1:0] new_upto;
    logic [CNT_W-1:0] rank;

    // Compare the incoming sample with every lane already loaded
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt_vec[i] = (LANE_W'(i) < load_lane) && (vals_reg[i] < load_data);
            le_vec[i] = (LANE_W'(i) < load_lane) && (vals_reg[i] <= load_data);
        end
        new_below = CNT_W'($countones(lt_vec));
        new_upto  = CNT_W'($countones(le_vec)) + CNT_W'(1);
    end

    // Each pair is compared once: older lanes update, the new lane takes its counts
    always_ff @(posedge clk) begin
        if (load_valid) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (LANE_W'(i) < load_lane) begin
                    below_reg[i] <= below_reg[i] + CNT_W'(load_data < vals_reg[i]);
                    upto_reg[i]  <= upto_reg[i] + CNT_W'(load_data <= vals_reg[i]);
                end else if (LANE_W'(i) == load_lane) begin
                    vals_reg[i]  <= load_data;
                    below_reg[i] <= new_below;
                    upto_reg[i]  <= new_upto;
                end
            end
        end
    end

    // Lanes that hold the rank all hold the same value, so an OR merges them
    always_comb begin
        rank   = used_count >> 1;
        median = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ((CNT_W'(i) < used_count) && (below_reg[i] <= rank) && (rank < upto_reg[i])) begin
                median = median | vals_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/smf_checker.sv */
// Port-level checker for the sliding median filter, bound to the top level.
`default_nettype none

module smf_checker import smf_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tlast,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [SMF_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The last sample always starts a flush, so input stalls right after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during flush");

    // A new result only appears after a median pass, when input was held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a median pass");

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (.*);

`default_nettype wire
